@@ rtl/core/sha256_pkg.sv @@
`default_nettype none

package sha256_pkg;

    // block byte positions that steer the padding sequence, and the last round and digest word indices
    localparam logic [5:0] POS_LAST  = 6'd63;
    localparam logic [5:0] POS_LEN   = 6'd56;
    localparam logic [5:0] ROUND_END = 6'd63;
    localparam logic [2:0] WORD_LAST = 3'd7;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAD80,
        ST_PADZ,
        ST_LEN,
        ST_INIT,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        BSEL_MSG,
        BSEL_PAD,
        BSEL_ZERO,
        BSEL_LEN
    } byte_sel_t;

    typedef struct packed {
        logic      push;
        byte_sel_t byte_sel;
        logic      count_inc;
        logic      load_len;
        logic      init_work;
        logic      round;
        logic      add_hash;
        logic      out_load;
        logic [2:0] out_idx;
        logic      restart;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [5:0] pos;
        logic       round_last;
        logic       out_free;
    } ctrl_status_t;

endpackage

`default_nettype wire

@@ rtl/core/sha256_dp.sv @@
`default_nettype none

module sha256_dp
    import sha256_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire ctrl_cmd_t    cmd,
    input  wire logic [7:0]   data_byte,
    input  wire logic         out_ready,
    output ctrl_status_t      status,
    output logic              out_valid,
    output logic [31:0]       digest_word,
    output logic [2:0]        word_index,
    output logic              last_word
);

    function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] w_reg    [0:15];
    logic [31:0] hash_reg [0:7];
    logic [31:0] var_reg  [0:7];
    logic [60:0] count_reg;
    logic [5:0]  pos_reg;
    logic [5:0]  rnd_reg;
    logic [63:0] len_reg;
    logic        out_valid_reg;
    logic [31:0] out_word_reg;
    logic [2:0]  out_idx_reg;
    logic        out_last_reg;

    logic [7:0]  push_byte;
    logic [31:0] sched_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] s0_w;
    logic [31:0] s1_w;
    logic [31:0] big_s0;
    logic [31:0] big_s1;
    logic [31:0] ch;
    logic [31:0] maj;

    always_comb
    begin
        case (cmd.byte_sel)
            BSEL_MSG:  push_byte = data_byte;
            BSEL_PAD:  push_byte = PAD_BYTE;
            BSEL_ZERO: push_byte = 8'h00;
            BSEL_LEN:  push_byte = len_reg[63:56];
            default:   push_byte = 8'h00;
        endcase
    end

    // message schedule and round function: w_reg[0] is the word used in the current round
    always_comb
    begin
        s0_w      = ror(w_reg[1], 7) ^ ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1_w      = ror(w_reg[14], 17) ^ ror(w_reg[14], 19) ^ (w_reg[14] >> 10);
        sched_new = w_reg[0] + s0_w + w_reg[9] + s1_w;
        big_s1    = ror(var_reg[4], 6) ^ ror(var_reg[4], 11) ^ ror(var_reg[4], 25);
        ch        = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
        big_s0    = ror(var_reg[0], 2) ^ ror(var_reg[0], 13) ^ ror(var_reg[0], 22);
        maj       = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
                  ^ (var_reg[1] & var_reg[2]);
        t1        = var_reg[7] + big_s1 + ch + ROUND_K[rnd_reg] + w_reg[0];
        t2        = big_s0 + maj;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            case (pos_reg[1:0])
                2'd0:
                begin
                    for (int i = 0; i < 15; i++)
                    begin
                        w_reg[i] <= w_reg[i + 1];
                    end
                    w_reg[15] <= {push_byte, 24'h000000};
                end
                2'd1:    w_reg[15][23:16] <= push_byte;
                2'd2:    w_reg[15][15:8]  <= push_byte;
                default: w_reg[15][7:0]   <= push_byte;
            endcase
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= sched_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_work)
        begin
            for (int i = 0; i < 8; i++)
            begin
                var_reg[i] <= hash_reg[i];
            end
        end
        else if (cmd.round)
        begin
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_len)
        begin
            len_reg <= {count_reg, 3'b000};
        end
        else if (cmd.push && (cmd.byte_sel == BSEL_LEN))
        begin
            len_reg <= {len_reg[55:0], 8'h00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= INIT_HASH[i];
            end
            count_reg <= '0;
            pos_reg   <= '0;
            rnd_reg   <= '0;
        end
        else
        begin
            if (cmd.restart)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= INIT_HASH[i];
                end
            end
            else if (cmd.add_hash)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= hash_reg[i] + var_reg[i];
                end
            end

            if (cmd.restart)
            begin
                count_reg <= '0;
            end
            else if (cmd.count_inc)
            begin
                count_reg <= count_reg + 61'd1;
            end

            if (cmd.restart)
            begin
                pos_reg <= '0;
            end
            else if (cmd.push)
            begin
                pos_reg <= pos_reg + 6'd1;
            end

            if (cmd.init_work)
            begin
                rnd_reg <= '0;
            end
            else if (cmd.round)
            begin
                rnd_reg <= rnd_reg + 6'd1;
            end
        end
    end

    // output register, holds a word until the consumer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_word_reg <= hash_reg[cmd.out_idx];
            out_idx_reg  <= cmd.out_idx;
            out_last_reg <= (cmd.out_idx == WORD_LAST);
        end
    end

    always_comb
    begin
        status.pos        = pos_reg;
        status.round_last = (rnd_reg == ROUND_END);
        status.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign digest_word = out_word_reg;
    assign word_index  = out_idx_reg;
    assign last_word   = out_last_reg;

endmodule

`default_nettype wire

@@ rtl/core/sha256_ctrl.sv @@
`default_nettype none

module sha256_ctrl
    import sha256_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         has_byte,
    input  wire logic         end_of_message,
    input  wire ctrl_status_t status,
    output logic              in_ready,
    output ctrl_cmd_t         cmd
);

    state_t     state_reg;
    state_t     state_next;
    state_t     ret_reg;
    state_t     ret_next;
    logic [2:0] out_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            out_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            if (cmd.out_load)
            begin
                out_idx_reg <= out_idx_reg + 3'd1;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (has_byte && (status.pos == POS_LAST))
                    begin
                        state_next = ST_INIT;
                        ret_next   = end_of_message ? ST_PAD80 : ST_IDLE;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD80;
                    end
                end
            end
            ST_PAD80:
            begin
                if (status.pos == POS_LAST)
                begin
                    state_next = ST_INIT;
                    ret_next   = ST_PADZ;
                end
                else
                begin
                    state_next = ST_PADZ;
                end
            end
            ST_PADZ:
            begin
                if (status.pos == POS_LEN)
                begin
                    state_next = ST_LEN;
                end
                else if (status.pos == POS_LAST)
                begin
                    state_next = ST_INIT;
                    ret_next   = ST_PADZ;
                end
            end
            ST_LEN:
            begin
                if (status.pos == POS_LAST)
                begin
                    state_next = ST_INIT;
                    ret_next   = ST_OUT;
                end
            end
            ST_INIT:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (status.round_last)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                state_next = ret_reg;
            end
            ST_OUT:
            begin
                if (status.out_free && (out_idx_reg == WORD_LAST))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.byte_sel  = BSEL_MSG;
        cmd.out_idx   = out_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && has_byte)
                begin
                    cmd.push      = 1'b1;
                    cmd.count_inc = 1'b1;
                end
            end
            ST_PAD80:
            begin
                cmd.push     = 1'b1;
                cmd.byte_sel = BSEL_PAD;
                cmd.load_len = 1'b1;
            end
            ST_PADZ:
            begin
                if (status.pos != POS_LEN)
                begin
                    cmd.push     = 1'b1;
                    cmd.byte_sel = BSEL_ZERO;
                end
            end
            ST_LEN:
            begin
                cmd.push     = 1'b1;
                cmd.byte_sel = BSEL_LEN;
            end
            ST_INIT:
            begin
                cmd.init_work = 1'b1;
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
            end
            ST_ADD:
            begin
                cmd.add_hash = 1'b1;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.restart  = (out_idx_reg == WORD_LAST);
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/sha256_message_hash.sv @@
`default_nettype none

// channel   direction  tdata                                     tuser          tlast
// s_*       in         [7:0] data_byte                           [0] has_byte   end_of_message
// m_*       out        [31:0] digest_word, [34:32] word_index,   none           last_word
//                      [39:35] zero
//
// message bytes are taken one per cycle while s_tready is high; every 64th byte
// (message or padding) starts a compression (load, 64 rounds at one per cycle,
// chain add), during which the input is stalled
// closing a message pads one byte a cycle between compressions up to byte 56 of
// the block, then sends 8 length bytes, with one or two compressions, then 8 digest words
// s_tready is high only while the controller waits for input; m_tready low
// holds the digest sequence, and the last word waits in the output register
// reset loads the initial hash and clears the byte count

module sha256_message_hash
    import sha256_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_tuser,   // [0] has_byte
    input  wire logic        s_tlast,   // end_of_message

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
    output logic             m_tlast    // last_word
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;
    logic [31:0]  digest_word;
    logic [2:0]   word_index;

    // controller: sequences absorb, padding, compression and digest output
    sha256_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .has_byte       (s_tuser[0]),
        .end_of_message (s_tlast),
        .status         (status),
        .in_ready       (s_tready),
        .cmd            (cmd)
    );

    // datapath: block shift line, round unit, chain hash and output register
    sha256_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (s_tdata),
        .out_ready   (m_tready),
        .status      (status),
        .out_valid   (m_tvalid),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (m_tlast)
    );

    assign m_tdata = {5'b00000, word_index, digest_word};

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`default_nettype none

module tb_top;

    // sha-256 round constants and initial chaining value, kept apart from the
    // rtl package so that a wrong table there cannot hide in the prediction
    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_H0 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // message lengths around the padding and block edges
    localparam int EDGE_LENS [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    localparam int RANDOM_ITEMS = 410;
    localparam int TAIL_CYCLES  = 300;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_AFTER   = 1000;
    localparam int MAX_PRINTS   = 40;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } hash_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_beat_t;

    logic        clk;
    logic        rst_n;

    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic [0:0]  s_tuser;   // [0] has_byte
    logic        s_tlast;   // end_of_message

    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [31:0] digest_word, [34:32] word_index, [39:35] zero
    logic        m_tlast;   // last_word

    sha256_message_hash u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // items waiting for the driver, digest words waiting for the monitor
    hash_item_t   pending_items [$];
    digest_beat_t digest_q [$];

    // predictor state: chaining value, current block as bytes, byte count
    logic [31:0] chain_h [8];
    logic [7:0]  block_bytes [64];
    logic [60:0] byte_count;

    int n_errors;
    int n_queued;
    int n_messages;
    int n_accepted;
    int n_ignored;
    int n_words;
    int cyc;
    int hold_left;
    bit hold_done;
    int stall_left;
    int send_gap;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    task automatic report_mismatch(string msg);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of block_bytes into chain_h
    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] t1, t2, s0, s1;
        int i;
        for (i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                    block_bytes[4*i+3]};
        for (i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
        e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
        for (i = 0; i < 64; i++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + SHA_K[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
        chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
    endtask

    task automatic hash_restart();
        int i;
        for (i = 0; i < 8; i++)
            chain_h[i] = SHA_H0[i];
        for (i = 0; i < 64; i++)
            block_bytes[i] = 8'h00;
        byte_count = '0;
    endtask

    // absorb one accepted transaction; a closing item pads and queues the digest
    task automatic absorb_item(logic [7:0] data_byte, logic has_byte, logic eom);
        logic [63:0]  bit_len;
        int           pos;
        int           i;
        digest_beat_t beat;
        if (has_byte) begin
            block_bytes[byte_count[5:0]] = data_byte;
            byte_count = byte_count + 1'b1;
            if (byte_count[5:0] == 6'd0)
                compress_block();
        end
        if (eom) begin
            bit_len = {byte_count, 3'b000};
            pos = int'(byte_count[5:0]);
            block_bytes[pos] = 8'h80;
            for (i = pos + 1; i < 64; i++)
                block_bytes[i] = 8'h00;
            // no room for the length field: an extra all-padding block
            if (pos >= 56) begin
                compress_block();
                for (i = 0; i < 64; i++)
                    block_bytes[i] = 8'h00;
            end
            for (i = 0; i < 8; i++)
                block_bytes[56 + i] = bit_len[63 - 8*i -: 8];
            compress_block();
            for (i = 0; i < 8; i++) begin
                beat.digest_word = chain_h[i];
                beat.word_index  = 3'(i);
                beat.last_word   = (i == 7);
                digest_q = {digest_q, beat};
            end
            hash_restart();
        end
    endtask

    function automatic hash_item_t mk_item(logic [7:0] d, logic has_byte, logic eom);
        hash_item_t it;
        it.data_byte      = d;
        it.has_byte       = has_byte;
        it.end_of_message = eom;
        return it;
    endfunction

    // append one item to the driver queue
    task automatic queue_item(hash_item_t it);
        pending_items = {pending_items, it};
        n_queued++;
    endtask

    // a message of len bytes, sprinkled with items that carry neither byte nor end;
    // it closes either on the last byte or with an empty closing item
    task automatic queue_message(int len);
        bit close_on_byte;
        int i;
        close_on_byte = ($urandom_range(0, 1) == 1) && (len > 0);
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
                queue_item(mk_item(8'($urandom), 1'b0, 1'b0));
            queue_item(mk_item(8'($urandom), 1'b1, close_on_byte && (i == len - 1)));
        end
        if (!close_on_byte)
            queue_item(mk_item(8'($urandom), 1'b0, 1'b1));
        n_messages++;
    endtask

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return 0;
        else if (sel < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 40);
    endfunction

    // driver: presents the next pending item, holds it until the handshake,
    // then leaves a random gap; the predictor runs on every accepted transaction
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tuser  <= 1'b0;
            s_tlast  <= 1'b0;
            send_gap <= 0;
        end
        else begin : drive_proc
            hash_item_t nxt;
            if (s_tvalid && s_tready) begin
                absorb_item(s_tdata, s_tuser[0], s_tlast);
                n_accepted++;
                if (!s_tuser[0] && !s_tlast)
                    n_ignored++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_items.size() != 0) begin
                    nxt = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data_byte;
                    s_tuser  <= nxt.has_byte;
                    s_tlast  <= nxt.end_of_message;
                    send_gap <= pick_gap();
                end
                else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // one long receiver hold-off, started while a digest word is waiting, so the
    // output backs up and the block has to stall its input
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cyc       <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else begin
            cyc <= cyc + 1;
            if (hold_left != 0)
                hold_left <= hold_left - 1;
            else if (!hold_done && cyc > HOLD_AFTER && m_tvalid) begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
        end
    end

    // receiver ready with random stalls, mostly short, a few long
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (hold_left != 0) begin
            m_tready <= 1'b0;
        end
        else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else begin
            m_tready   <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // monitor: each digest transaction against the oldest expected word
    always @(posedge clk) begin : monitor_proc
        digest_beat_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (digest_q.size() == 0) begin
                report_mismatch($sformatf("unexpected digest transaction %h", m_tdata));
            end
            else begin
                want = digest_q.pop_front();
                n_words++;
                if (m_tdata[31:0] !== want.digest_word)
                    report_mismatch($sformatf("digest_word[%0d] expected %h got %h",
                                              want.word_index, want.digest_word,
                                              m_tdata[31:0]));
                if (m_tdata[34:32] !== want.word_index)
                    report_mismatch($sformatf("word_index expected %0d got %0d",
                                              want.word_index, m_tdata[34:32]));
                if (m_tlast !== want.last_word)
                    report_mismatch($sformatf("last_word at index %0d expected %b got %b",
                                              want.word_index, want.last_word, m_tlast));
            end
        end
    end

    // stimulus, reset and end of run
    initial begin : stim_proc
        int sel;
        rst_n      = 1'b0;
        n_errors   = 0;
        n_queued   = 0;
        n_messages = 0;
        n_accepted = 0;
        n_ignored  = 0;
        n_words    = 0;
        hash_restart();

        // directed: empty message, a lone ignored item, "abc" closed on its last
        // byte, single extreme bytes, an empty closing item after bytes, and an
        // ignored item in the middle of a message, then a second empty message
        queue_item(mk_item(8'h00, 1'b0, 1'b1));
        queue_item(mk_item(8'ha5, 1'b0, 1'b0));
        queue_item(mk_item(8'h61, 1'b1, 1'b0));
        queue_item(mk_item(8'h62, 1'b1, 1'b0));
        queue_item(mk_item(8'h63, 1'b1, 1'b1));
        queue_item(mk_item(8'hff, 1'b1, 1'b1));
        queue_item(mk_item(8'h00, 1'b1, 1'b1));
        queue_item(mk_item(8'h00, 1'b1, 1'b0));
        queue_item(mk_item(8'hff, 1'b0, 1'b1));
        queue_item(mk_item(8'h80, 1'b1, 1'b0));
        queue_item(mk_item(8'hff, 1'b0, 1'b0));
        queue_item(mk_item(8'h7f, 1'b1, 1'b0));
        queue_item(mk_item(8'h01, 1'b1, 1'b1));
        queue_item(mk_item(8'hff, 1'b0, 1'b1));
        n_messages = 7;

        // random messages, mostly short, some on the padding and block edges
        while (n_queued < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
                queue_message($urandom_range(0, 8));
            else if (sel < 77)
                queue_message($urandom_range(9, 40));
            else
                queue_message(EDGE_LENS[$urandom_range(0, 9)]);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (pending_items.size() != 0 || s_tvalid)
            @(posedge clk);
        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (digest_q.size() != 0)
            report_mismatch($sformatf("%0d digest words never arrived", digest_q.size()));

        $display("covered %0d input transactions (%0d ignored) in %0d messages",
                 n_accepted, n_ignored, n_messages);
        $display("checked %0d digest words, %0d mismatches, long output hold %s",
                 n_words, n_errors, hold_done ? "done" : "not reached");
        if (n_errors == 0)
            $display("[sha256_message_hash] OK");
        else
            $display("[sha256_message_hash] ERROR");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #40000000;
        $display("timeout with %0d digest words outstanding", digest_q.size());
        $display("[sha256_message_hash] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/core/sha256_pkg.sv
rtl/core/sha256_dp.sv
rtl/core/sha256_ctrl.sv
rtl/core/sha256_message_hash.sv
dv/tb_top.sv
